### rtl/moving_average_line_segments_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the moving average line segment block
// Clocked property shorthands used by the checker of this block.
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_LINE_SEGMENTS_TOP_MACROS_SVH
`define MOVING_AVERAGE_LINE_SEGMENTS_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MALS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mals_checker: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define MALS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mals_checker: next-cycle check failed");

`endif

### rtl/mals_pkg.sv
// ----------------------------------------------------------------------------
// Moving average line segment package
// Sizes, register indexes, reset values and the divider step of the block;
// its checker and testbench import the package as well.
// ----------------------------------------------------------------------------
package mals_pkg;

    localparam int MAX_PERIOD = 256;

    localparam int PRICE_W   = 32;
    localparam int CLIP_W    = 16;
    localparam int PERIOD_W  = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    localparam int PTR_W = $clog2(MAX_PERIOD);
    localparam int CNT_W = $clog2(MAX_PERIOD + 1);
    localparam int CMP_W = (CNT_W > PERIOD_W) ? CNT_W : PERIOD_W;
    localparam int SUM_W = PRICE_W + PTR_W;

    localparam int DIFF_W  = PRICE_W + 1;
    localparam int CDIFF_W = CLIP_W + 1;
    localparam int PROD_W  = DIFF_W + CDIFF_W;

    localparam int MAG_RAW   = (SUM_W > PROD_W - 1) ? SUM_W : PROD_W - 1;
    localparam int MAG_W     = MAG_RAW + (MAG_RAW % 2);
    localparam int DIV_STEPS = MAG_W / 2;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int DVS_W     = DIFF_W;
    localparam int REM_W     = DVS_W + 1;
    localparam int YF_W      = MAG_W + 2;

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_MIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_MAX      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_Y_MIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_Y_MAX = 3'd4;

    localparam logic [PERIOD_W-1:0] PERIOD_RST     = 9'd20;
    localparam logic [PRICE_W-1:0]  Y_MIN_RST      = 32'h0000_0000;
    localparam logic [PRICE_W-1:0]  Y_MAX_RST      = 32'h0001_0000;
    localparam logic [CLIP_W-1:0]   CLIP_Y_MIN_RST = 16'hC000;
    localparam logic [CLIP_W-1:0]   CLIP_Y_MAX_RST = 16'h4000;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic             q;
    } div_step_t;

    // One restoring division step: bring in the next dividend bit and
    // subtract the divisor where it fits.
    function automatic div_step_t div_step(
        input logic [REM_W-1:0] rem,
        input logic             bit_in,
        input logic [DVS_W-1:0] dvs
    );
        div_step_t        res;
        logic [REM_W-1:0] shifted;
        logic [REM_W-1:0] dvs_ext;
        shifted = {rem[REM_W-2:0], bit_in};
        dvs_ext = {1'b0, dvs};
        if (shifted >= dvs_ext)
        begin
            res.rem = shifted - dvs_ext;
            res.q   = 1'b1;
        end
        else
        begin
            res.rem = shifted;
            res.q   = 1'b0;
        end
        return res;
    endfunction

endpackage

### rtl/mals_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mals_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/moving_average_line_segments_top.sv
// ----------------------------------------------------------------------------
// Moving average line segment builder
// Averages a price stream over a configurable window, maps the average into
// clip space and emits a segment from the previous averaged point to each new one.
// ----------------------------------------------------------------------------
// A price transaction that completes a window holds in_ready low from
// acceptance until it is done: two passes of one shared radix-4
// restoring divider (two quotient bits per cycle over a 50-bit dividend)
// dominate, beside the window RAM read, the sum update, the 33x17
// multiply, the two divider loads and the map, saturate and emit steps.
// With a flat data range the multiply and the second division are skipped,
// a transaction that leaves the window partly filled ends after the RAM read
// and the sum update, and with a zero period the block stays in idle. A
// finished segment waits in the output register while the next transaction is
// accepted; the emit step stalls only if a second segment is ready before the
// first is taken.
// ----------------------------------------------------------------------------
module moving_average_line_segments_top
    import mals_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [PRICE_W-1:0]   price,
    input  logic signed [CLIP_W-1:0]    x_pos,
    input  logic                        series_start,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [CLIP_W-1:0]    seg_x0,
    output logic signed [CLIP_W-1:0]    seg_y0,
    output logic signed [CLIP_W-1:0]    seg_x1,
    output logic signed [CLIP_W-1:0]    seg_y1,
    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_LOAD_AVG,
        S_DIV_AVG,
        S_MAP,
        S_MUL,
        S_LOAD_MAP,
        S_DIV_MAP,
        S_SAT,
        S_EMIT
    } state_t;

    state_t               state_reg, state_next;
    logic [PERIOD_W-1:0]  period_reg, period_next;
    logic [PRICE_W-1:0]   y_min_reg, y_min_next;
    logic [PRICE_W-1:0]   y_max_reg, y_max_next;
    logic [CLIP_W-1:0]    clip_min_reg, clip_min_next;
    logic [CLIP_W-1:0]    clip_max_reg, clip_max_next;

    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic [PTR_W-1:0]     wp_reg, wp_next;
    logic [CLIP_W-1:0]    prev_x_reg, prev_x_next;
    logic [CLIP_W-1:0]    prev_y_reg, prev_y_next;
    logic                 prev_valid_reg, prev_valid_next;

    logic [PRICE_W-1:0]   price_reg, price_next;
    logic [CLIP_W-1:0]    x_reg, x_next;
    logic [CLIP_W-1:0]    y_reg, y_next;
    logic [DIFF_W-1:0]    diff_reg, diff_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;

    logic [MAG_W-1:0]     dvd_reg, dvd_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [DVS_W-1:0]     dvs_reg, dvs_next;
    logic                 neg_reg, neg_next;
    logic [STEP_W-1:0]    step_reg, step_next;

    logic                 out_valid_reg, out_valid_next;
    logic [CLIP_W-1:0]    seg_x0_reg, seg_x0_next;
    logic [CLIP_W-1:0]    seg_y0_reg, seg_y0_next;
    logic [CLIP_W-1:0]    seg_x1_reg, seg_x1_next;
    logic [CLIP_W-1:0]    seg_y1_reg, seg_y1_next;

    logic [CNT_W-1:0]     p_eff;
    logic [CNT_W-1:0]     wp_ext;
    logic [PTR_W-1:0]     old_addr;
    logic [CNT_W-1:0]     fill_inc;
    logic [PRICE_W-1:0]   rd_data;
    logic                 ram_rd_en;
    logic                 ram_wr_en;
    logic [SUM_W-1:0]     price_ext;
    logic [SUM_W-1:0]     old_ext;
    logic [SUM_W-1:0]     sum_mag;
    logic [PROD_W-1:0]    prod_mag;
    logic [DIFF_W-1:0]    den;
    logic [DIFF_W-1:0]    den_mag;
    logic [CDIFF_W-1:0]   cdiff;
    logic [DIFF_W-1:0]    quo_avg;
    logic [DIFF_W-1:0]    avg;
    logic [MAG_W:0]       quo_ext;
    logic [MAG_W:0]       quo_signed;
    logic [YF_W-1:0]      y_full;
    logic [CLIP_W-1:0]    y_sat;
    div_step_t            step_a;
    div_step_t            step_b;

    mals_ram #(
        .WIDTH (PRICE_W),
        .DEPTH (MAX_PERIOD)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wp_reg),
        .wr_data (price_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (old_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        if (CMP_W'(period_reg) > CMP_W'(MAX_PERIOD))
        begin
            p_eff = CNT_W'(MAX_PERIOD);
        end
        else
        begin
            p_eff = CNT_W'(period_reg);
        end

        wp_ext = CNT_W'(wp_reg);
        if (wp_ext >= p_eff)
        begin
            old_addr = PTR_W'(wp_ext - p_eff);
        end
        else
        begin
            old_addr = PTR_W'(wp_ext + CNT_W'(MAX_PERIOD) - p_eff);
        end

        if (fill_reg < CNT_W'(MAX_PERIOD))
        begin
            fill_inc = fill_reg + 1'b1;
        end
        else
        begin
            fill_inc = fill_reg;
        end

        price_ext = {{(SUM_W - PRICE_W){price_reg[PRICE_W-1]}}, price_reg};
        if (fill_reg >= p_eff)
        begin
            old_ext = {{(SUM_W - PRICE_W){rd_data[PRICE_W-1]}}, rd_data};
        end
        else
        begin
            old_ext = '0;
        end

        sum_mag  = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
        prod_mag = prod_reg[PROD_W-1] ? (~prod_reg + 1'b1) : prod_reg;

        den     = {y_max_reg[PRICE_W-1], y_max_reg} - {y_min_reg[PRICE_W-1], y_min_reg};
        den_mag = den[DIFF_W-1] ? (~den + 1'b1) : den;
        cdiff   = {clip_max_reg[CLIP_W-1], clip_max_reg}
                - {clip_min_reg[CLIP_W-1], clip_min_reg};

        quo_avg = dvd_reg[DIFF_W-1:0];
        avg     = neg_reg ? (~quo_avg + 1'b1) : quo_avg;

        quo_ext    = {1'b0, dvd_reg};
        quo_signed = neg_reg ? (~quo_ext + 1'b1) : quo_ext;
        y_full     = {quo_signed[MAG_W], quo_signed}
                   + {{(YF_W - CLIP_W){clip_min_reg[CLIP_W-1]}}, clip_min_reg};
        if (!y_full[YF_W-1] && (y_full[YF_W-2:CLIP_W-1] != '0))
        begin
            y_sat = {1'b0, {(CLIP_W - 1){1'b1}}};
        end
        else if (y_full[YF_W-1] && (y_full[YF_W-2:CLIP_W-1] != '1))
        begin
            y_sat = {1'b1, {(CLIP_W - 1){1'b0}}};
        end
        else
        begin
            y_sat = y_full[CLIP_W-1:0];
        end

        step_a = div_step(rem_reg, dvd_reg[MAG_W-1], dvs_reg);
        step_b = div_step(step_a.rem, dvd_reg[MAG_W-2], dvs_reg);
    end

    always_comb
    begin
        state_next      = state_reg;
        period_next     = period_reg;
        y_min_next      = y_min_reg;
        y_max_next      = y_max_reg;
        clip_min_next   = clip_min_reg;
        clip_max_next   = clip_max_reg;
        sum_next        = sum_reg;
        fill_next       = fill_reg;
        wp_next         = wp_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        prev_valid_next = prev_valid_reg;
        price_next      = price_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        diff_next       = diff_reg;
        prod_next       = prod_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        dvs_next        = dvs_reg;
        neg_next        = neg_reg;
        step_next       = step_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        seg_x0_next     = seg_x0_reg;
        seg_y0_next     = seg_y0_reg;
        seg_x1_next     = seg_x1_reg;
        seg_y1_next     = seg_y1_reg;
        ram_rd_en       = 1'b0;
        ram_wr_en       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    price_next = price;
                    x_next     = x_pos;
                    if (series_start)
                    begin
                        sum_next        = '0;
                        fill_next       = '0;
                        wp_next         = '0;
                        prev_valid_next = 1'b0;
                    end
                    if (period_reg != '0)
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                ram_rd_en  = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                ram_wr_en = 1'b1;
                sum_next  = sum_reg - old_ext + price_ext;
                fill_next = fill_inc;
                if (wp_reg == PTR_W'(MAX_PERIOD - 1))
                begin
                    wp_next = '0;
                end
                else
                begin
                    wp_next = wp_reg + 1'b1;
                end
                if (fill_inc < p_eff)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_LOAD_AVG;
                end
            end
            S_LOAD_AVG:
            begin
                dvd_next   = MAG_W'(sum_mag);
                rem_next   = '0;
                dvs_next   = DVS_W'(p_eff);
                neg_next   = sum_reg[SUM_W-1];
                step_next  = '0;
                state_next = S_DIV_AVG;
            end
            S_DIV_AVG, S_DIV_MAP:
            begin
                dvd_next  = {dvd_reg[MAG_W-3:0], step_a.q, step_b.q};
                rem_next  = step_b.rem;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = (state_reg == S_DIV_AVG) ? S_MAP : S_SAT;
                end
            end
            S_MAP:
            begin
                diff_next = avg - {y_min_reg[PRICE_W-1], y_min_reg};
                if (den == '0)
                begin
                    y_next     = clip_min_reg;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = PROD_W'($signed(diff_reg) * $signed(cdiff));
                state_next = S_LOAD_MAP;
            end
            S_LOAD_MAP:
            begin
                dvd_next   = MAG_W'(prod_mag);
                rem_next   = '0;
                dvs_next   = den_mag;
                neg_next   = prod_reg[PROD_W-1] ^ den[DIFF_W-1];
                step_next  = '0;
                state_next = S_DIV_MAP;
            end
            S_SAT:
            begin
                y_next     = y_sat;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!(prev_valid_reg && out_valid_reg && !out_ready))
                begin
                    if (prev_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        seg_x0_next    = prev_x_reg;
                        seg_y0_next    = prev_y_reg;
                        seg_x1_next    = x_reg;
                        seg_y1_next    = y_reg;
                    end
                    prev_x_next     = x_reg;
                    prev_y_next     = y_reg;
                    prev_valid_next = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_PERIOD:
                begin
                    period_next     = cfg_data[PERIOD_W-1:0];
                    sum_next        = '0;
                    fill_next       = '0;
                    wp_next         = '0;
                    prev_valid_next = 1'b0;
                end
                REG_Y_MIN:      y_min_next    = cfg_data[PRICE_W-1:0];
                REG_Y_MAX:      y_max_next    = cfg_data[PRICE_W-1:0];
                REG_CLIP_Y_MIN: clip_min_next = cfg_data[CLIP_W-1:0];
                REG_CLIP_Y_MAX: clip_max_next = cfg_data[CLIP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            period_reg     <= PERIOD_RST;
            y_min_reg      <= Y_MIN_RST;
            y_max_reg      <= Y_MAX_RST;
            clip_min_reg   <= CLIP_Y_MIN_RST;
            clip_max_reg   <= CLIP_Y_MAX_RST;
            sum_reg        <= '0;
            fill_reg       <= '0;
            wp_reg         <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            prev_valid_reg <= 1'b0;
            price_reg      <= '0;
            x_reg          <= '0;
            y_reg          <= '0;
            diff_reg       <= '0;
            prod_reg       <= '0;
            dvd_reg        <= '0;
            rem_reg        <= '0;
            dvs_reg        <= '0;
            neg_reg        <= 1'b0;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
            seg_x0_reg     <= '0;
            seg_y0_reg     <= '0;
            seg_x1_reg     <= '0;
            seg_y1_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            period_reg     <= period_next;
            y_min_reg      <= y_min_next;
            y_max_reg      <= y_max_next;
            clip_min_reg   <= clip_min_next;
            clip_max_reg   <= clip_max_next;
            sum_reg        <= sum_next;
            fill_reg       <= fill_next;
            wp_reg         <= wp_next;
            prev_x_reg     <= prev_x_next;
            prev_y_reg     <= prev_y_next;
            prev_valid_reg <= prev_valid_next;
            price_reg      <= price_next;
            x_reg          <= x_next;
            y_reg          <= y_next;
            diff_reg       <= diff_next;
            prod_reg       <= prod_next;
            dvd_reg        <= dvd_next;
            rem_reg        <= rem_next;
            dvs_reg        <= dvs_next;
            neg_reg        <= neg_next;
            step_reg       <= step_next;
            out_valid_reg  <= out_valid_next;
            seg_x0_reg     <= seg_x0_next;
            seg_y0_reg     <= seg_y0_next;
            seg_x1_reg     <= seg_x1_next;
            seg_y1_reg     <= seg_y1_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign seg_x0    = seg_x0_reg;
    assign seg_y0    = seg_y0_reg;
    assign seg_x1    = seg_x1_reg;
    assign seg_y1    = seg_y1_reg;

endmodule

### rtl/mals_checker.sv
// ----------------------------------------------------------------------------
// Moving average line segment port checker
// Watches the handshakes of the block and the ordering of its transactions.
// ----------------------------------------------------------------------------
`include "moving_average_line_segments_top_macros.svh"

module mals_checker
    import mals_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [CLIP_W-1:0] seg_x0,
    input logic [CLIP_W-1:0] seg_y0,
    input logic [CLIP_W-1:0] seg_x1,
    input logic [CLIP_W-1:0] seg_y1
);

    logic [4*CLIP_W-1:0] seg_all;

    assign seg_all = {seg_x0, seg_y0, seg_x1, seg_y1};

    // A segment that is not taken stays offered.
    `MALS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // A stalled segment keeps its coordinates.
    `MALS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(seg_all))

    // An idle block with no offered transaction stays ready.
    `MALS_ASSERT_NEXT(a_idle_holds, in_ready && !in_valid, in_ready)

    // A new segment only appears as the block finishes working on a sample.
    `MALS_ASSERT_SAME(a_segment_from_work, $rose(out_valid), $past(!in_ready))

endmodule

bind moving_average_line_segments_top mals_checker u_mals_checker (.*);

### verif/tb_moving_average_line_segments_top.sv
// ----------------------------------------------------------------------------
// Testbench for the moving average line segment builder
// Sends price transactions over valid/ready, with random idle cycles on both
// sides, and sets the window and mapping registers between phases. A short
// table of directed transactions covers the field extremes, saturation, a flat
// and an inverted data range, a zero period and series restarts. A long
// random run follows over many settings, including the largest periods. Every
// segment is checked field by field against the typed values of its row or a
// cycle-free prediction of the window sum, average and clip-space mapping.
// ----------------------------------------------------------------------------
module tb_moving_average_line_segments_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mals_pkg::*;

    localparam int DRAIN_CYCLES = 80;
    localparam int RAND_ITEMS   = 400;

    typedef struct packed {
        logic signed [CLIP_W-1:0] x0;
        logic signed [CLIP_W-1:0] y0;
        logic signed [CLIP_W-1:0] x1;
        logic signed [CLIP_W-1:0] y1;
    } seg_t;

    typedef enum logic [1:0] {ROW_REG, ROW_PREDICT, ROW_NO_SEG, ROW_SEG} row_kind_t;

    typedef struct {
        row_kind_t                 kind;
        logic [CFG_IDX_W-1:0]      idx;
        logic [CFG_W-1:0]          data;
        logic signed [PRICE_W-1:0] smp;
        logic signed [CLIP_W-1:0]  xp;
        bit                        start;
        seg_t                      seg;
    } stim_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic signed [PRICE_W-1:0]  price;
    logic signed [CLIP_W-1:0]   x_pos;
    logic                       series_start;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [CLIP_W-1:0]   seg_x0;
    logic signed [CLIP_W-1:0]   seg_y0;
    logic signed [CLIP_W-1:0]   seg_x1;
    logic signed [CLIP_W-1:0]   seg_y1;
    logic                       cfg_wr_en;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_W-1:0]           cfg_data;

    // Predicted block state and register copies.
    logic signed [PRICE_W-1:0]  win_ring [MAX_PERIOD];
    longint                     win_sum;
    int unsigned                fill_cnt;
    int unsigned                wr_ptr;
    logic signed [CLIP_W-1:0]   last_x;
    logic signed [CLIP_W-1:0]   last_y;
    bit                         last_ok;
    logic [PERIOD_W-1:0]        win_period;
    logic signed [PRICE_W-1:0]  y_lo;
    logic signed [PRICE_W-1:0]  y_hi;
    logic signed [CLIP_W-1:0]   clip_lo;
    logic signed [CLIP_W-1:0]   clip_hi;

    seg_t        pending_segs [$];
    stim_row_t   directed [$];
    int          fail_cnt     = 0;
    int          items_sent   = 0;
    int          segs_checked = 0;
    int          reg_writes   = 0;
    int          phases       = 0;
    bit          gaps_on      = 1'b1;
    bit          dirty        = 1'b0;

    moving_average_line_segments_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .price        (price),
        .x_pos        (x_pos),
        .series_start (series_start),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .seg_x0       (seg_x0),
        .seg_y0       (seg_y0),
        .seg_x1       (seg_x1),
        .seg_y1       (seg_y1),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void expect_seg(input seg_t seg);
        pending_segs.insert(pending_segs.size(), seg);
    endfunction

    function automatic void add_row(input stim_row_t row);
        directed.insert(directed.size(), row);
    endfunction

    function automatic void clear_window();
        win_sum  = 0;
        fill_cnt = 0;
        wr_ptr   = 0;
        last_ok  = 1'b0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] val);
        case (idx)
            REG_PERIOD:
            begin
                win_period = val[PERIOD_W-1:0];
                clear_window();
            end
            REG_Y_MIN:      y_lo    = val;
            REG_Y_MAX:      y_hi    = val;
            REG_CLIP_Y_MIN: clip_lo = val[CLIP_W-1:0];
            REG_CLIP_Y_MAX: clip_hi = val[CLIP_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic bit advance_average(input logic signed [PRICE_W-1:0] smp,
                                           input logic signed [CLIP_W-1:0] xp,
                                           input bit start,
                                           output seg_t seg);
        int unsigned eff;
        longint      avg;
        longint      den;
        longint      yv;
        bit          emitted;
        seg = '0;
        if (start)
            clear_window();
        if (win_period == 0)
            return 1'b0;
        eff = (win_period > MAX_PERIOD) ? MAX_PERIOD : win_period;
        if (fill_cnt >= eff)
            win_sum -= longint'(win_ring[(wr_ptr + MAX_PERIOD - eff) % MAX_PERIOD]);
        win_ring[wr_ptr] = smp;
        win_sum += longint'(smp);
        wr_ptr = (wr_ptr + 1 >= MAX_PERIOD) ? 0 : wr_ptr + 1;
        if (fill_cnt < MAX_PERIOD)
            fill_cnt++;
        if (fill_cnt < eff)
            return 1'b0;
        avg = win_sum / longint'(eff);
        den = longint'(y_hi) - longint'(y_lo);
        if (den == 0)
            yv = longint'(clip_lo);
        else
            yv = longint'(clip_lo) + ((avg - longint'(y_lo))
                 * (longint'(clip_hi) - longint'(clip_lo))) / den;
        if (yv > 32767)
            yv = 32767;
        if (yv < -32768)
            yv = -32768;
        emitted = last_ok;
        seg.x0  = last_x;
        seg.y0  = last_y;
        seg.x1  = xp;
        seg.y1  = CLIP_W'(yv);
        last_x  = xp;
        last_y  = CLIP_W'(yv);
        last_ok = 1'b1;
        return emitted;
    endfunction

    function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] val);
        stim_row_t row;
        row.kind  = ROW_REG;
        row.idx   = idx;
        row.data  = val;
        row.smp   = '0;
        row.xp    = '0;
        row.start = 1'b0;
        row.seg   = '0;
        return row;
    endfunction

    function automatic stim_row_t item_row(input row_kind_t kind,
                                           input logic signed [PRICE_W-1:0] smp,
                                           input logic signed [CLIP_W-1:0] xp,
                                           input bit start,
                                           input logic signed [CLIP_W-1:0] x0,
                                           input logic signed [CLIP_W-1:0] y0,
                                           input logic signed [CLIP_W-1:0] x1,
                                           input logic signed [CLIP_W-1:0] y1);
        stim_row_t row;
        row.kind   = kind;
        row.idx    = '0;
        row.data   = '0;
        row.smp    = smp;
        row.xp     = xp;
        row.start  = start;
        row.seg.x0 = x0;
        row.seg.y0 = y0;
        row.seg.x1 = x1;
        row.seg.y1 = y1;
        return row;
    endfunction

    function automatic void check_field(input string name,
                                        input logic signed [CLIP_W-1:0] want,
                                        input logic signed [CLIP_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_cnt++;
        end
    endfunction

    task automatic send_item(input logic signed [PRICE_W-1:0] smp,
                             input logic signed [CLIP_W-1:0] xp,
                             input bit start,
                             input row_kind_t kind,
                             input seg_t typed);
        int unsigned gap;
        seg_t        predicted;
        bit          emitted;
        gap = gaps_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        price        <= smp;
        x_pos        <= xp;
        series_start <= start;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        emitted = advance_average(smp, xp, start, predicted);
        if (kind == ROW_SEG)
            expect_seg(typed);
        else if (kind == ROW_PREDICT && emitted)
            expect_seg(predicted);
        items_sent++;
        dirty = 1'b1;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        in_valid <= 1'b0;
        if (dirty)
        begin
            while (pending_segs.size() != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
            dirty = 1'b0;
        end
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        apply_reg(idx, val);
        reg_writes++;
    endtask

    task automatic run_phase(input int unsigned per, input int unsigned n_items,
                             input int unsigned start_odds);
        longint                    lo;
        longint                    hi;
        longint                    t;
        longint                    plo;
        longint                    phi;
        longint unsigned           r;
        logic signed [CLIP_W-1:0]  c_lo;
        logic signed [CLIP_W-1:0]  c_hi;
        logic signed [PRICE_W-1:0] smp;
        bit                        start;
        int unsigned               i;
        case ($urandom_range(0, 5))
            0:
            begin
                lo = longint'(32'sh8000_0000);
                hi = longint'(32'sh7FFF_FFFF);
            end
            1:
            begin
                lo = longint'($signed($urandom));
                hi = lo;
            end
            default:
            begin
                lo = longint'($signed($urandom)) >>> 1;
                hi = lo + longint'($urandom_range(1, 1 << 24));
            end
        endcase
        if ($urandom_range(0, 4) == 0)
        begin
            t  = lo;
            lo = hi;
            hi = t;
        end
        case ($urandom_range(0, 3))
            0:
            begin
                c_lo = 16'sh8000;
                c_hi = 16'sh7FFF;
            end
            1:
            begin
                c_lo = 16'sh7FFF;
                c_hi = 16'sh8000;
            end
            2:
            begin
                c_lo = CLIP_W'($urandom);
                c_hi = CLIP_W'($urandom);
            end
            default:
            begin
                c_lo = -16'sd16384;
                c_hi = 16'sd16384;
            end
        endcase
        gaps_on = ($urandom_range(0, 3) != 0);
        phases++;
        write_reg(REG_Y_MIN, CFG_W'(lo));
        write_reg(REG_Y_MAX, CFG_W'(hi));
        write_reg(REG_CLIP_Y_MIN, CFG_W'(c_lo));
        write_reg(REG_CLIP_Y_MAX, CFG_W'(c_hi));
        write_reg(REG_PERIOD, CFG_W'(per));
        plo = (lo < hi) ? lo : hi;
        phi = (lo < hi) ? hi : lo;
        for (i = 0; i < n_items; i++)
        begin
            if ($urandom_range(0, 3) == 0 || plo == phi)
                smp = $urandom;
            else
            begin
                r   = {$urandom, $urandom};
                smp = PRICE_W'(plo + longint'(r % longint'(phi - plo + 1)));
            end
            start = (start_odds != 0) && ($urandom_range(1, start_odds) == 1);
            send_item(smp, CLIP_W'($urandom), start, ROW_PREDICT, '0);
        end
    endtask

    initial
    begin
        int unsigned stall;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = gaps_on ? $urandom_range(0, 4) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    always @(posedge clk)
    begin
        seg_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_segs.size() == 0)
            begin
                $error("segment with no expectation: x0 %0d y0 %0d x1 %0d y1 %0d",
                       seg_x0, seg_y0, seg_x1, seg_y1);
                fail_cnt++;
            end
            else
            begin
                want = pending_segs.pop_front();
                check_field("seg_x0", want.x0, seg_x0);
                check_field("seg_y0", want.y0, seg_y0);
                check_field("seg_x1", want.x1, seg_x1);
                check_field("seg_y1", want.y1, seg_y1);
                segs_checked++;
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("Timeout: %0d segments still outstanding", pending_segs.size());
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int unsigned rand_count;
        int unsigned sel;
        int unsigned per;
        int unsigned n;
        rand_count   = 0;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        price        <= '0;
        x_pos        <= '0;
        series_start <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;

        win_period = PERIOD_RST;
        y_lo       = Y_MIN_RST;
        y_hi       = Y_MAX_RST;
        clip_lo    = CLIP_Y_MIN_RST;
        clip_hi    = CLIP_Y_MAX_RST;
        last_x     = '0;
        last_y     = '0;
        clear_window();

        add_row(reg_row(REG_PERIOD, 32'd1));
        add_row(item_row(ROW_NO_SEG, 32'sd0, 16'sh8000, 1'b1, '0, '0, '0, '0));
        add_row(item_row(ROW_SEG, 32'sh0001_0000, 16'sh7FFF, 1'b0,
                         16'sh8000, -16'sd16384, 16'sh7FFF, 16'sd16384));
        add_row(item_row(ROW_SEG, 32'sh7FFF_FFFF, 16'sd0, 1'b0,
                         16'sh7FFF, 16'sd16384, 16'sd0, 16'sh7FFF));
        add_row(item_row(ROW_SEG, 32'sh8000_0000, 16'sd1, 1'b0,
                         16'sd0, 16'sh7FFF, 16'sd1, 16'sh8000));
        add_row(item_row(ROW_NO_SEG, 32'sd0, 16'sd100, 1'b1, '0, '0, '0, '0));
        add_row(item_row(ROW_SEG, 32'sd32768, 16'sd200, 1'b0,
                         16'sd100, -16'sd16384, 16'sd200, 16'sd0));
        add_row(reg_row(REG_Y_MAX, 32'd0));
        add_row(item_row(ROW_SEG, 32'sd5, 16'sd300, 1'b0,
                         16'sd200, 16'sd0, 16'sd300, -16'sd16384));
        add_row(item_row(ROW_PREDICT, -32'sd7, -16'sd300, 1'b0, '0, '0, '0, '0));
        add_row(reg_row(REG_CLIP_Y_MIN, 32'hFFFF_8000));
        add_row(reg_row(REG_CLIP_Y_MAX, 32'h0000_7FFF));
        add_row(reg_row(REG_Y_MIN, 32'h8000_0000));
        add_row(reg_row(REG_Y_MAX, 32'h7FFF_FFFF));
        add_row(item_row(ROW_PREDICT, 32'sh8000_0000, 16'sh8000, 1'b0, '0, '0, '0, '0));
        add_row(item_row(ROW_PREDICT, 32'sh7FFF_FFFF, 16'sh7FFF, 1'b0, '0, '0, '0, '0));
        add_row(item_row(ROW_PREDICT, 32'sd0, 16'sd0, 1'b0, '0, '0, '0, '0));
        add_row(reg_row(REG_Y_MIN, 32'h0001_0000));
        add_row(reg_row(REG_Y_MAX, 32'd0));
        add_row(item_row(ROW_PREDICT, 32'sd1, 16'sd5, 1'b0, '0, '0, '0, '0));
        add_row(item_row(ROW_PREDICT, -32'sd100000, -16'sd5, 1'b0, '0, '0, '0, '0));
        add_row(reg_row(REG_PERIOD, 32'd0));
        add_row(item_row(ROW_NO_SEG, 32'sd100, 16'sd10, 1'b0, '0, '0, '0, '0));
        add_row(item_row(ROW_NO_SEG, 32'sd200, 16'sd20, 1'b1, '0, '0, '0, '0));
        add_row(reg_row(REG_PERIOD, 32'd2));
        add_row(item_row(ROW_NO_SEG, 32'sd10, 16'sd30, 1'b0, '0, '0, '0, '0));
        add_row(item_row(ROW_NO_SEG, 32'sd20, 16'sd40, 1'b0, '0, '0, '0, '0));
        add_row(item_row(ROW_PREDICT, 32'sd30, 16'sd50, 1'b0, '0, '0, '0, '0));
        add_row(item_row(ROW_PREDICT, -32'sd40, 16'sd60, 1'b0, '0, '0, '0, '0));
        add_row(item_row(ROW_NO_SEG, 32'sd50, 16'sd70, 1'b1, '0, '0, '0, '0));
        add_row(item_row(ROW_NO_SEG, 32'sd60, 16'sd80, 1'b0, '0, '0, '0, '0));
        add_row(item_row(ROW_PREDICT, 32'sd70, 16'sd90, 1'b0, '0, '0, '0, '0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[k])
        begin
            if (directed[k].kind == ROW_REG)
                write_reg(directed[k].idx, directed[k].data);
            else
                send_item(directed[k].smp, directed[k].xp, directed[k].start,
                          directed[k].kind, directed[k].seg);
        end

        while (rand_count < RAND_ITEMS)
        begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
            begin
                per = 0;
                n   = 8;
            end
            else if (sel <= 2)
            begin
                per = $urandom_range(9, 40);
                n   = per + $urandom_range(20, 50);
            end
            else
            begin
                per = $urandom_range(1, 8);
                n   = $urandom_range(20, 60);
            end
            run_phase(per, n, (per == 0) ? 4 : 40);
            rand_count += n;
        end
        run_phase(256, 290, 0);
        run_phase(511, 290, 0);

        in_valid <= 1'b0;
        while (pending_segs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d price transactions and %0d checked segments over %0d settings.",
                 items_sent, segs_checked, phases);
        $display("%0d register writes, with zero, full and oversized periods, flat and inverted ranges.",
                 reg_writes);
        if (fail_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### moving_average_line_segments_top.f
+incdir+rtl
rtl/mals_pkg.sv
rtl/mals_ram.sv
rtl/moving_average_line_segments_top.sv
rtl/mals_checker.sv
verif/tb_moving_average_line_segments_top.sv
